/* rtl/core/hav_pkg.sv */
// hav_pkg: shared types, fixed-point constants and the arctangent table
// for the haversine distance pipeline. No dependencies.

package hav_pkg;

    localparam int CW = 34;
    localparam int SW = 63;
    localparam int SQRT_STEPS = 32;

    typedef logic signed [CW-1:0] t_cw;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [SW-1:0] n;
        logic [SW-1:0] r;
    } t_sq;

    localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
    localparam logic        [31:0] RAD_SCALE   = 32'd4024455254;
    localparam logic signed [CW-1:0] GAIN_Q30  = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30   = 34'sd1073741824;
    localparam logic        [29:0] RADIUS_CM   = 30'd637100000;
    localparam logic        [30:0] MAX_CM      = 31'd2001508680;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd7;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/haversine_distance.sv */
// haversine_distance: pipelined great-circle distance between two positions.
// Depends on hav_pkg, hav_rot_cell, hav_sqrt_cell, hav_vec_cell.
//
//   channel | handshake          | payload
//   in      | i_valid / o_ready  | i_first_latitude, i_first_longitude,
//           |                    | i_second_latitude, i_second_longitude
//   out     | o_valid / i_ready  | o_distance_cm
//
// One word accepted per cycle while the output is not stalled; the path runs
// through the rotation and vectoring CORDIC cell rows and the 32-digit square-root rows.
// The whole pipeline advances together; it holds while o_valid is high and
// i_ready is low, and o_ready follows.
// Reset clears only the valid chain.

module haversine_distance #(
    parameter int CORDIC_STEPS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [30:0] i_first_latitude,
    input  logic signed [31:0] i_first_longitude,
    input  logic signed [30:0] i_second_latitude,
    input  logic signed [31:0] i_second_longitude,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [30:0] o_distance_cm
);

    localparam int LAT   = 2 * CORDIC_STEPS + 48;
    localparam int POS_M = CORDIC_STEPS + 12;
    localparam int CW    = hav_pkg::CW;
    localparam int SQN   = hav_pkg::SQRT_STEPS;
    localparam logic signed [35:0] TURN36 = 36'sd3600000000;
    localparam logic signed [35:0] HALF36 = 36'sd1800000000;

    function automatic logic signed [31:0] wrap(input logic signed [33:0] d);
        logic signed [35:0] e;
        e = 36'(d);
        if (e > HALF36) begin
            e = e - TURN36;
        end else if (e < -HALF36) begin
            e = e + TURN36;
        end
        return e[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
        return v[CW-1] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [31:0] rnd30(input logic [63:0] p);
        logic [64:0] t;
        t = {1'b0, p} + 65'h2000_0000;
        return t[61:30];
    endfunction

    logic adv;
    logic [LAT-1:0] r_vld;

    // front end
    logic signed [31:0] n_a_w   [4];
    logic signed [31:0] r_a_w   [4];
    logic        [30:0] n_b_mag [4];
    logic               n_b_neg [4];
    logic        [30:0] r_b_mag [4];
    logic               r_b_neg [4];
    logic        [62:0] n_c_p   [4];
    logic        [62:0] r_c_p   [4];
    logic               r_c_neg [4];
    logic signed [31:0] n_d_th  [4];
    logic signed [31:0] r_d_th  [4];
    hav_pkg::t_rot      n_e     [4];
    hav_pkg::t_rot      r_e     [4];
    hav_pkg::t_rot      w_rot   [4][CORDIC_STEPS+1];

    // haversine term
    logic signed [CW-1:0] r_f_c1, r_f_c2, r_f_sd, r_f_se;
    logic [31:0] r_g_c1, r_g_c2, r_g_sd, r_g_se;
    logic        r_g_neg, r_h_neg, r_i_neg, r_j_neg, r_k_neg;
    logic [63:0] n_h_sd, n_h_cc, n_h_se;
    logic [63:0] r_h_sd, r_h_cc, r_h_se;
    logic [31:0] r_i_sd, r_i_cc, r_i_se;
    logic [63:0] n_j_p, r_j_p;
    logic [31:0] r_j_sd, r_k_sd, r_k_m;
    logic signed [CW-1:0] n_l_s, r_l_s;
    logic [30:0] n_m_a, r_m_a, r_m_b;

    hav_pkg::t_sq  w_sqa [SQN+1];
    hav_pkg::t_sq  w_sqb [SQN+1];
    hav_pkg::t_vec w_vec [CORDIC_STEPS+1];

    logic [31:0] n_n_z, r_n_z;
    logic [61:0] n_o_p, r_o_p;
    logic [63:0] p_t;
    logic [30:0] n_p_d, r_p_d;

    assign adv     = !r_vld[LAT-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[LAT-1];
    assign o_distance_cm = r_p_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        n_a_w[0] = 32'(i_first_latitude);
        n_a_w[1] = 32'(i_second_latitude);
        n_a_w[2] = wrap(34'(i_second_latitude) - 34'(i_first_latitude));
        n_a_w[3] = wrap(34'(i_second_longitude) - 34'(i_first_longitude));
        for (int l = 0; l < 4; l++) begin
            n_b_neg[l] = r_a_w[l][31];
            n_b_mag[l] = r_a_w[l][31] ? 31'(-r_a_w[l]) : 31'(r_a_w[l]);
            n_c_p[l]   = 63'(r_b_mag[l]) * 63'(hav_pkg::RAD_SCALE);
        end
    end

    always_comb begin
        logic [63:0] t;
        logic signed [31:0] m;
        logic signed [31:0] th;
        for (int l = 0; l < 4; l++) begin
            t = {1'b0, r_c_p[l]} + 64'h8000_0000;
            m = $signed({1'b0, t[62:32]});
            n_d_th[l] = r_c_neg[l] ? -m : m;
            if (l >= 2) begin
                n_d_th[l] = n_d_th[l] >>> 1;
            end
            th = r_d_th[l];
            n_e[l].flip = 1'b0;
            if (th > hav_pkg::HALF_PI_Q29) begin
                th = hav_pkg::PI_Q29 - th;
                n_e[l].flip = 1'b1;
            end else if (th < -hav_pkg::HALF_PI_Q29) begin
                th = -hav_pkg::PI_Q29 - th;
                n_e[l].flip = 1'b1;
            end
            n_e[l].x = hav_pkg::GAIN_Q30;
            n_e[l].y = '0;
            n_e[l].z = CW'(th) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                r_a_w[l]   <= n_a_w[l];
                r_b_mag[l] <= n_b_mag[l];
                r_b_neg[l] <= n_b_neg[l];
                r_c_p[l]   <= n_c_p[l];
                r_c_neg[l] <= r_b_neg[l];
                r_d_th[l]  <= n_d_th[l];
                r_e[l]     <= n_e[l];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign w_rot[l][0] = r_e[l];
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
            hav_rot_cell #(.STEP(k)) u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_d   (w_rot[l][k]),
                .o_d   (w_rot[l][k+1])
            );
        end
    end

    always_comb begin
        n_h_sd = 64'(r_g_sd) * 64'(r_g_sd);
        n_h_cc = 64'(r_g_c1) * 64'(r_g_c2);
        n_h_se = 64'(r_g_se) * 64'(r_g_se);
        n_j_p  = 64'(r_i_cc) * 64'(r_i_se);
        if (r_k_neg) begin
            n_l_s = $signed({2'b0, r_k_sd}) - $signed({2'b0, r_k_m});
        end else begin
            n_l_s = $signed({2'b0, r_k_sd}) + $signed({2'b0, r_k_m});
        end
        if (r_l_s[CW-1]) begin
            n_m_a = '0;
        end else if (r_l_s > hav_pkg::ONE_Q30) begin
            n_m_a = 31'(hav_pkg::ONE_Q30);
        end else begin
            n_m_a = r_l_s[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_c1 <= w_rot[0][CORDIC_STEPS].flip ? -w_rot[0][CORDIC_STEPS].x
                                                  : w_rot[0][CORDIC_STEPS].x;
            r_f_c2 <= w_rot[1][CORDIC_STEPS].flip ? -w_rot[1][CORDIC_STEPS].x
                                                  : w_rot[1][CORDIC_STEPS].x;
            r_f_sd <= w_rot[2][CORDIC_STEPS].y;
            r_f_se <= w_rot[3][CORDIC_STEPS].y;
            r_g_c1 <= mag32(r_f_c1);
            r_g_c2 <= mag32(r_f_c2);
            r_g_sd <= mag32(r_f_sd);
            r_g_se <= mag32(r_f_se);
            r_g_neg <= r_f_c1[CW-1] ^ r_f_c2[CW-1];
            r_h_sd <= n_h_sd;
            r_h_cc <= n_h_cc;
            r_h_se <= n_h_se;
            r_h_neg <= r_g_neg;
            r_i_sd <= rnd30(r_h_sd);
            r_i_cc <= rnd30(r_h_cc);
            r_i_se <= rnd30(r_h_se);
            r_i_neg <= r_h_neg;
            r_j_p  <= n_j_p;
            r_j_sd <= r_i_sd;
            r_j_neg <= r_i_neg;
            r_k_m  <= rnd30(r_j_p);
            r_k_sd <= r_j_sd;
            r_k_neg <= r_j_neg;
            r_l_s  <= n_l_s;
            r_m_a  <= n_m_a;
            r_m_b  <= 31'(hav_pkg::ONE_Q30) - n_m_a;
        end
    end

    assign w_sqa[0].n = hav_pkg::SW'({r_m_a, 30'b0});
    assign w_sqa[0].r = '0;
    assign w_sqb[0].n = hav_pkg::SW'({r_m_b, 30'b0});
    assign w_sqb[0].r = '0;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        hav_sqrt_cell #(.STEP(k)) u_sqa (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (w_sqa[k]),
            .o_d   (w_sqa[k+1])
        );
        hav_sqrt_cell #(.STEP(k)) u_sqb (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (w_sqb[k]),
            .o_d   (w_sqb[k+1])
        );
    end

    assign w_vec[0].x = CW'(w_sqb[SQN].r);
    assign w_vec[0].y = CW'(w_sqa[SQN].r);
    assign w_vec[0].z = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        hav_vec_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (w_vec[k]),
            .o_d   (w_vec[k+1])
        );
    end

    always_comb begin
        n_n_z = w_vec[CORDIC_STEPS].z[CW-1] ? '0 : w_vec[CORDIC_STEPS].z[31:0];
        n_o_p = 62'(r_n_z) * 62'(hav_pkg::RADIUS_CM);
        p_t   = {2'b0, r_o_p} + 64'h1000_0000;
        if (p_t[63:29] > 35'(hav_pkg::MAX_CM)) begin
            n_p_d = hav_pkg::MAX_CM;
        end else begin
            n_p_d = p_t[59:29];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_z <= n_n_z;
            r_o_p <= n_o_p;
            r_p_d <= n_p_d;
        end
    end

    a_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_cm <= hav_pkg::MAX_CM)
        else $error("distance above half circumference");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_vld) && $stable(r_m_a))
        else $error("pipeline moved during stall");

    a_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[POS_M] |-> r_m_a + r_m_b == 31'(hav_pkg::ONE_Q30))
        else $error("haversine term out of range");

endmodule

/* rtl/core/hav_rot_cell.sv */
// hav_rot_cell: one registered CORDIC rotation step (sine/cosine).
// Depends on hav_pkg.

module hav_rot_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  hav_pkg::t_rot i_d,
    output hav_pkg::t_rot o_d
);

    localparam logic signed [hav_pkg::CW-1:0] ATAN =
        (hav_pkg::CW)'(hav_pkg::atan_q30(STEP));

    hav_pkg::t_rot r_d;
    hav_pkg::t_rot n_d;
    logic signed [hav_pkg::CW-1:0] dx;
    logic signed [hav_pkg::CW-1:0] dy;

    always_comb begin
        dx = i_d.y >>> STEP;
        dy = i_d.x >>> STEP;
        n_d.flip = i_d.flip;
        if (!i_d.z[hav_pkg::CW-1]) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/core/hav_sqrt_cell.sv */
// hav_sqrt_cell: one registered digit of the shift-and-subtract square root.
// Depends on hav_pkg.

module hav_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  hav_pkg::t_sq i_d,
    output hav_pkg::t_sq o_d
);

    localparam logic [hav_pkg::SW-1:0] BIT =
        {{(hav_pkg::SW-1){1'b0}}, 1'b1} << (2 * (hav_pkg::SQRT_STEPS - 1 - STEP));

    hav_pkg::t_sq r_d;
    hav_pkg::t_sq n_d;
    logic [hav_pkg::SW-1:0] trial;

    always_comb begin
        trial = i_d.r + BIT;
        if (i_d.n >= trial) begin
            n_d.n = i_d.n - trial;
            n_d.r = (i_d.r >> 1) + BIT;
        end else begin
            n_d.n = i_d.n;
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/core/hav_vec_cell.sv */
// hav_vec_cell: one registered CORDIC vectoring step (arctangent).
// Depends on hav_pkg.

module hav_vec_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  hav_pkg::t_vec i_d,
    output hav_pkg::t_vec o_d
);

    localparam logic signed [hav_pkg::CW-1:0] ATAN =
        (hav_pkg::CW)'(hav_pkg::atan_q30(STEP));

    hav_pkg::t_vec r_d;
    hav_pkg::t_vec n_d;
    logic signed [hav_pkg::CW-1:0] dx;
    logic signed [hav_pkg::CW-1:0] dy;

    always_comb begin
        dx = i_d.y >>> STEP;
        dy = i_d.x >>> STEP;
        if (!i_d.y[hav_pkg::CW-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ATAN;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
